>>> design/mips_subset_single_cycle_core_assert.svh
// Assertion macros shared by the core. Each one checks a property on the rising
// edge of aclk. Checks made with MSSC_ASSERT are disabled while aresetn is low.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH

// Checked property that is disabled while reset is asserted.
`define MSSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property that also runs during reset.
`define MSSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/mssc_pkg.sv
`timescale 1ns / 1ps

package mssc_pkg;

    // Default depth of the data memory, in words.
    localparam int DATA_WORDS_DEFAULT = 32;

    // Request types.
    localparam logic [1:0] REQ_EXEC     = 2'd0;
    localparam logic [1:0] REQ_LOAD_REG = 2'd1;
    localparam logic [1:0] REQ_LOAD_MEM = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Opcodes and R-type function codes.
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SLT   = 6'd42;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]          req_type;
        logic [31:0]         instr;
        logic [4:0]          load_index;
        logic signed [31:0]  load_value;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [31:0]         next_pc;
        logic                reg_written;
        logic [4:0]          reg_index;
        logic signed [31:0]  reg_value;
        logic                mem_written;
        logic [6:0]          mem_byte_address;
        logic signed [31:0]  mem_value;
        logic [1:0]          status;
        logic [31:0]         executed_count;
    } out_item_t;

endpackage

>>> design/mips_subset_single_cycle_core.sv
// Core for the MIPS subset lw, sw, sub, slt and beq, plus preloads of a register or
// a data memory word. It takes one item per clock and keeps taking items at that
// rate while the output is not stalled. The item is held in the operand stage and
// then moves into the result register. The register file is read when the item is
// taken. The data memory is read and written when the item moves into the result
// register. Results that are not yet in the register file are forwarded, so
// dependent instructions never stall. The result register decouples the two sides,
// and outside the clearing sweep the input only waits when both the operand stage
// and the result register are full and m_ready is low. After reset, a clearing
// sweep zeroes the register file and data memory, with s_ready low while it runs.
`timescale 1ns / 1ps
`include "mips_subset_single_cycle_core_assert.svh"

module mips_subset_single_cycle_core #(
    parameter int DATA_WORDS = mssc_pkg::DATA_WORDS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mssc_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output mssc_pkg::out_item_t m_payload
);

    localparam int AW    = $clog2(DATA_WORDS);
    localparam int CLR_N = (DATA_WORDS > 32) ? DATA_WORDS : 32;
    localparam int CW    = $clog2(CLR_N + 1);

    // Storage.
    logic [31:0] rf_mem [32];
    logic [31:0] dmem [DATA_WORDS];

    // Clearing sweep.
    logic [CW-1:0] clr_cnt_reg;
    logic          clearing;

    // Operand stage.
    logic                s1_valid_reg;
    mssc_pkg::in_item_t  s1_reg;
    logic [31:0]         rs_data_reg;
    logic [31:0]         rt_data_reg;

    // Result stage.
    logic                m_valid_reg;
    mssc_pkg::out_item_t res_reg;
    logic                res_load_reg;
    logic                wb_pending_reg;
    logic [31:0]         mem_rdata_reg;

    // Architectural counters.
    logic [31:0] pc_reg;
    logic [31:0] count_reg;

    // Handshake.
    logic advance;
    logic accept;

    // Writeback.
    logic        wb_we;
    logic        wb_fwd;
    logic [4:0]  wb_idx;
    logic [31:0] wb_val;

    // Operand read selection.
    logic [4:0]  rs_sel;
    logic [4:0]  rt_sel;
    logic [31:0] rs_data_next;
    logic [31:0] rt_data_next;

    // Execute stage.
    logic [5:0]          op;
    logic [5:0]          funct;
    logic [4:0]          rs;
    logic [4:0]          rt;
    logic [4:0]          rd;
    logic [31:0]         imm_sext;
    logic [31:0]         opa;
    logic [31:0]         opb;
    logic [31:0]         pc4;
    logic [31:0]         addr;
    logic                addr_ok;
    mssc_pkg::out_item_t s1_res;
    logic                s1_load;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_widx;
    logic [31:0]         mem_wdata;
    logic [31:0]         pc_next;
    logic                cnt_inc;
    logic [31:0]         count_next;

    assign clearing = (clr_cnt_reg < CW'(CLR_N));

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing && (!s1_valid_reg || advance);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Writeback happens in the cycle after an item enters the result register.
    assign wb_fwd = wb_pending_reg && res_reg.reg_written;
    assign wb_we  = wb_fwd;
    assign wb_idx = res_reg.reg_index;
    assign wb_val = res_load_reg ? mem_rdata_reg : $unsigned(res_reg.reg_value);

    // Result output with the loaded word merged in.
    always_comb begin
        m_payload           = res_reg;
        m_payload.reg_value = $signed(wb_val);
    end

    // Sweep counter runs once after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    // Register file write port.
    always_ff @(posedge aclk) begin
        if (clearing) begin
            if (clr_cnt_reg < CW'(32)) begin
                rf_mem[clr_cnt_reg[4:0]] <= '0;
            end
        end else if (wb_we) begin
            rf_mem[wb_idx] <= wb_val;
        end
    end

    // The operand registers read on accept and snoop writes that land later.
    assign rs_sel = accept ? s_payload.instr[25:21] : s1_reg.instr[25:21];
    assign rt_sel = accept ? s_payload.instr[20:16] : s1_reg.instr[20:16];

    always_comb begin
        if (wb_we && wb_idx == rs_sel) begin
            rs_data_next = wb_val;
        end else if (accept) begin
            rs_data_next = rf_mem[rs_sel];
        end else begin
            rs_data_next = rs_data_reg;
        end
        if (wb_we && wb_idx == rt_sel) begin
            rt_data_next = wb_val;
        end else if (accept) begin
            rt_data_next = rf_mem[rt_sel];
        end else begin
            rt_data_next = rt_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rs_data_reg <= rs_data_next;
        rt_data_reg <= rt_data_next;
        if (accept) begin
            s1_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Decode fields of the item in the operand stage.
    assign op       = s1_reg.instr[31:26];
    assign rs       = s1_reg.instr[25:21];
    assign rt       = s1_reg.instr[20:16];
    assign rd       = s1_reg.instr[15:11];
    assign funct    = s1_reg.instr[5:0];
    assign imm_sext = {{16{s1_reg.instr[15]}}, s1_reg.instr[15:0]};

    // Forward the result still waiting for writeback.
    assign opa = (wb_fwd && wb_idx == rs) ? wb_val : rs_data_reg;
    assign opb = (wb_fwd && wb_idx == rt) ? wb_val : rt_data_reg;

    assign pc4     = pc_reg + 32'd4;
    assign addr    = opa + imm_sext;
    assign addr_ok = ({2'b00, addr[31:2]} < 32'(DATA_WORDS));

    // Execute and build the result.
    always_comb begin
        s1_res    = '0;
        s1_load   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_widx  = '0;
        mem_wdata = '0;
        pc_next   = pc_reg;
        cnt_inc   = 1'b0;
        unique case (s1_reg.req_type)
            mssc_pkg::REQ_LOAD_REG: begin
                if (s1_reg.load_index != 5'd0) begin
                    s1_res.reg_written = 1'b1;
                    s1_res.reg_index   = s1_reg.load_index;
                    s1_res.reg_value   = s1_reg.load_value;
                end
            end
            mssc_pkg::REQ_LOAD_MEM: begin
                if (32'(s1_reg.load_index) < 32'(DATA_WORDS)) begin
                    mem_we                  = 1'b1;
                    mem_widx                = AW'(s1_reg.load_index);
                    mem_wdata               = s1_reg.load_value;
                    s1_res.mem_written      = 1'b1;
                    s1_res.mem_byte_address = {s1_reg.load_index, 2'b00};
                    s1_res.mem_value        = s1_reg.load_value;
                end else begin
                    s1_res.status = mssc_pkg::ST_RANGE;
                end
            end
            mssc_pkg::REQ_RESERVED: begin
                s1_res.status = mssc_pkg::ST_UNSUP;
            end
            mssc_pkg::REQ_EXEC: begin
                pc_next = pc4;
                unique case (op)
                    mssc_pkg::OP_RTYPE: begin
                        unique case (funct)
                            mssc_pkg::FN_SUB: begin
                                cnt_inc = 1'b1;
                                if (rd != 5'd0) begin
                                    s1_res.reg_written = 1'b1;
                                    s1_res.reg_index   = rd;
                                    s1_res.reg_value   = $signed(opa - opb);
                                end
                            end
                            mssc_pkg::FN_SLT: begin
                                cnt_inc = 1'b1;
                                if (rd != 5'd0) begin
                                    s1_res.reg_written = 1'b1;
                                    s1_res.reg_index   = rd;
                                    s1_res.reg_value   =
                                        {31'd0, ($signed(opa) < $signed(opb))};
                                end
                            end
                            default: begin
                                s1_res.status = mssc_pkg::ST_UNSUP;
                            end
                        endcase
                    end
                    mssc_pkg::OP_BEQ: begin
                        cnt_inc = 1'b1;
                        if (opa == opb) begin
                            pc_next = pc4 + {imm_sext[29:0], 2'b00};
                        end
                    end
                    mssc_pkg::OP_LW: begin
                        cnt_inc                 = 1'b1;
                        s1_res.mem_byte_address = addr[6:0];
                        if (!addr_ok) begin
                            s1_res.status = mssc_pkg::ST_RANGE;
                        end else begin
                            mem_re   = 1'b1;
                            mem_widx = AW'(addr[31:2]);
                            if (rt != 5'd0) begin
                                s1_res.reg_written = 1'b1;
                                s1_res.reg_index   = rt;
                                s1_load            = 1'b1;
                            end
                        end
                    end
                    mssc_pkg::OP_SW: begin
                        cnt_inc                 = 1'b1;
                        s1_res.mem_byte_address = addr[6:0];
                        if (!addr_ok) begin
                            s1_res.status = mssc_pkg::ST_RANGE;
                        end else begin
                            mem_we             = 1'b1;
                            mem_widx           = AW'(addr[31:2]);
                            mem_wdata          = opb;
                            s1_res.mem_written = 1'b1;
                            s1_res.mem_value   = $signed(opb);
                        end
                    end
                    default: begin
                        s1_res.status = mssc_pkg::ST_UNSUP;
                    end
                endcase
            end
            default: begin
                s1_res.status = mssc_pkg::ST_UNSUP;
            end
        endcase
        s1_res.next_pc        = pc_next;
        s1_res.executed_count = count_next;
    end

    assign count_next = count_reg + {31'd0, cnt_inc};

    // Data memory: clearing sweep, then one access per advancing item.
    always_ff @(posedge aclk) begin
        if (clearing) begin
            if (clr_cnt_reg < CW'(DATA_WORDS)) begin
                dmem[clr_cnt_reg[AW-1:0]] <= '0;
            end
        end else if (advance && mem_we) begin
            dmem[mem_widx] <= mem_wdata;
        end
        if (advance && mem_re) begin
            mem_rdata_reg <= dmem[mem_widx];
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg      <= s1_res;
            res_load_reg <= s1_load;
        end
    end

    // Result control, program counter and instruction count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            wb_pending_reg <= 1'b0;
            pc_reg         <= '0;
            count_reg      <= '0;
        end else begin
            wb_pending_reg <= advance;
            if (advance) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= pc_next;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // A pending writeback always belongs to the item shown at the output.
    `MSSC_ASSERT(a_wb_has_result, wb_pending_reg |-> m_valid_reg, "writeback without result")

    // Register zero is only ever written by the clearing sweep.
    `MSSC_ASSERT(a_no_r0_write, wb_we |-> (wb_idx != 5'd0), "write to register zero")

    // The instruction count grows by at most one per cycle.
    `MSSC_ASSERT(a_count_step, 1'b1 |=> ((count_reg - $past(count_reg)) <= 32'd1), "count jumped")

    // An item in the operand stage moves on when the result register is free.
    `MSSC_ASSERT(a_s1_moves, (s1_valid_reg && !m_valid_reg) |=> m_valid_reg, "operand stage stuck")

endmodule
